// File: rtl/lrupr_pkg.sv
`timescale 1ns / 1ps
package lrupr_pkg;

  // fixed field widths of the channels
  localparam int unsigned PageInBits  = 16;
  localparam int unsigned SlotOutBits = 3;
  localparam int unsigned CfgBits     = 4;
  localparam int unsigned FaultBits   = 32;

  // build defaults
  localparam int unsigned FramesDefault   = 8;
  localparam int unsigned PageBitsDefault = 16;

  // frames_in_use after reset
  localparam logic [CfgBits-1:0] FramesInUseReset = 4'd8;

endpackage

// File: rtl/lrupr_lookup.sv
`timescale 1ns / 1ps
module lrupr_lookup
  import lrupr_pkg::*;
#(
  parameter int unsigned FRAMES   = FramesDefault,
  parameter int unsigned TAG_BITS = PageBitsDefault,
  localparam int unsigned SlotBits = (FRAMES > 1) ? $clog2(FRAMES) : 1,
  localparam int unsigned CntBits  = $clog2(FRAMES + 1)
) (
  input  logic [TAG_BITS-1:0] tag_i,
  input  logic [CntBits-1:0]  count_i,
  input  logic [FRAMES-1:0]   valid_i,
  input  logic [TAG_BITS-1:0] tags_i  [FRAMES],
  input  logic [SlotBits-1:0] ranks_i [FRAMES],
  output logic                hit_o,
  output logic [SlotBits-1:0] hit_slot_o,
  output logic [SlotBits-1:0] victim_slot_o
);

  // first matching frame below the active count
  always_comb begin
    hit_o      = 1'b0;
    hit_slot_o = '0;
    for (int k = FRAMES - 1; k >= 0; k--) begin
      if (k < int'(count_i) && valid_i[k] && tags_i[k] == tag_i) begin
        hit_o      = 1'b1;
        hit_slot_o = SlotBits'(k);
      end
    end
  end

  // oldest rank among active frames, lowest index on a tie
  logic [SlotBits-1:0] best_rank;

  always_comb begin
    victim_slot_o = '0;
    best_rank     = ranks_i[0];
    for (int k = 1; k < FRAMES; k++) begin
      if (k < int'(count_i) && ranks_i[k] > best_rank) begin
        victim_slot_o = SlotBits'(k);
        best_rank     = ranks_i[k];
      end
    end
  end

endmodule

// File: rtl/lru_page_replacement_unit.sv
`timescale 1ns / 1ps
// lru page replacement unit
//
// input channel: one page reference per beat (page_number_i, last_of_string_i),
//   accepted on a rising edge with in_valid_i high and in_stall_o low
// output channel: one result beat per reference (fault, slot, evicted page,
//   running fault total), taken on a rising edge with out_valid_o high and
//   out_stall_i low
// config channel: cfg_frames_in_use_i written when cfg_valid_i is high;
//   cfg_ready_o is always high. 0 acts as 1, values above FRAMES act as FRAMES
// path: input beat into the input register, then
//   tag compare, lru pick and rank update into the result register
// throughput: one reference per cycle when not stalled; the frame tags are compared in
//   parallel and all recency ranks update in the same cycle, so a reference
//   may follow in the very next cycle and sees the state the previous one left
// stall: while the result register is full and stalled, the input register
//   holds and in_stall_o rises once it is occupied too; nothing is dropped
// reset: all frames empty, fault total zero, frames_in_use back to 8
// a reference marked last clears frames and fault total after its result
module lru_page_replacement_unit
  import lrupr_pkg::*;
#(
  parameter int unsigned FRAMES    = FramesDefault,
  parameter int unsigned PAGE_BITS = PageBitsDefault
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,

  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [CfgBits-1:0]     cfg_frames_in_use_i,

  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic [PageInBits-1:0]  page_number_i,
  input  logic                   last_of_string_i,

  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic                   fault_o,
  output logic [SlotOutBits-1:0] slot_o,
  output logic                   evicted_valid_o,
  output logic [PageInBits-1:0]  evicted_page_o,
  output logic [FaultBits-1:0]   fault_total_o
);

  // page bits that take part in the compare
  localparam int unsigned TagBits  = (PAGE_BITS < PageInBits) ? PAGE_BITS : PageInBits;
  localparam int unsigned SlotBits = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam int unsigned CntBits  = $clog2(FRAMES + 1);

  // config register
  logic [CfgBits-1:0] frames_in_use_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frames_in_use_q <= FramesInUseReset;
    end else if (cfg_valid_i) begin
      frames_in_use_q <= cfg_frames_in_use_i;
    end
  end

  // clamp the active frame count into 1..FRAMES
  logic [CntBits-1:0] active_cnt;

  always_comb begin
    if (frames_in_use_q == '0) begin
      active_cnt = CntBits'(1);
    end else if (int'(frames_in_use_q) > FRAMES) begin
      active_cnt = CntBits'(FRAMES);
    end else begin
      active_cnt = CntBits'(frames_in_use_q);
    end
  end

  // pipeline handshake
  logic in_valid_q;
  logic out_valid_q;
  logic out_free;
  logic advance;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign advance    = in_valid_q && out_free;
  assign in_stall_o = in_valid_q && !out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (!in_stall_o) begin
        in_valid_q <= in_valid_i;
      end
      if (out_free) begin
        out_valid_q <= in_valid_q;
      end
    end
  end

  assign out_valid_o = out_valid_q;

  // input register
  logic [PageInBits-1:0] page_q;
  logic                  last_q;

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      page_q <= page_number_i;
      last_q <= last_of_string_i;
    end
  end

  // frame state
  logic [TagBits-1:0]   tags_q   [FRAMES];
  logic [FRAMES-1:0]    valid_q;
  logic [SlotBits-1:0]  ranks_q  [FRAMES];
  logic [CntBits-1:0]   filled_q;
  logic [FaultBits-1:0] fault_cnt_q;

  logic [TagBits-1:0] tag;
  logic               hit;
  logic [SlotBits-1:0] hit_slot;
  logic [SlotBits-1:0] victim_slot;

  assign tag = page_q[TagBits-1:0];

  lrupr_lookup #(
    .FRAMES  (FRAMES),
    .TAG_BITS(TagBits)
  ) u_lookup (
    .tag_i        (tag),
    .count_i      (active_cnt),
    .valid_i      (valid_q),
    .tags_i       (tags_q),
    .ranks_i      (ranks_q),
    .hit_o        (hit),
    .hit_slot_o   (hit_slot),
    .victim_slot_o(victim_slot)
  );

  // fill while empty frames remain below the active count, else evict
  logic                 do_fill;
  logic                 do_evict;
  logic [SlotBits-1:0]  slot_sel;
  logic [SlotBits-1:0]  old_rank;
  logic [FaultBits-1:0] fault_cnt_d;

  assign do_fill  = !hit && (filled_q < active_cnt);
  assign do_evict = !hit && !do_fill;

  always_comb begin
    if (hit) begin
      slot_sel = hit_slot;
    end else if (do_fill) begin
      slot_sel = filled_q[SlotBits-1:0];
    end else begin
      slot_sel = victim_slot;
    end
  end

  assign old_rank = ranks_q[slot_sel];

  // saturating fault counter
  always_comb begin
    fault_cnt_d = fault_cnt_q;
    if (!hit && fault_cnt_q != '1) begin
      fault_cnt_d = fault_cnt_q + FaultBits'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q     <= '0;
      filled_q    <= '0;
      fault_cnt_q <= '0;
      for (int k = 0; k < FRAMES; k++) begin
        ranks_q[k] <= '0;
      end
    end else if (advance) begin
      if (last_q) begin
        // end of string: back to empty
        valid_q     <= '0;
        filled_q    <= '0;
        fault_cnt_q <= '0;
        for (int k = 0; k < FRAMES; k++) begin
          ranks_q[k] <= '0;
        end
      end else begin
        fault_cnt_q <= fault_cnt_d;
        if (do_fill) begin
          valid_q[slot_sel] <= 1'b1;
          filled_q          <= filled_q + CntBits'(1);
        end
        // touched frame becomes most recent, newer valid frames age by one
        for (int k = 0; k < FRAMES; k++) begin
          if (SlotBits'(k) == slot_sel) begin
            ranks_q[k] <= '0;
          end else if (valid_q[k] && (do_fill || ranks_q[k] < old_rank)) begin
            ranks_q[k] <= ranks_q[k] + SlotBits'(1);
          end
        end
      end
    end
  end

  // tags carry no reset, only frames marked valid are ever compared
  always_ff @(posedge clk_i) begin
    if (advance && !hit) begin
      tags_q[slot_sel] <= tag;
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (advance) begin
      fault_o         <= !hit;
      slot_o          <= SlotOutBits'(slot_sel);
      evicted_valid_o <= do_evict;
      evicted_page_o  <= do_evict ? PageInBits'(tags_q[slot_sel]) : '0;
      fault_total_o   <= fault_cnt_d;
    end
  end

  // the number of valid frames matches the fill count
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(valid_q) == int'(filled_q))
    else $error("valid frame count differs from fill count");

  // a last reference leaves the block empty
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && last_q |=> filled_q == '0 && fault_cnt_q == '0)
    else $error("state not cleared after last reference");

  // a hit that is not marked last never changes the fault total
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && hit && !last_q |=> fault_cnt_q == $past(fault_cnt_q))
    else $error("fault total moved on a hit");

  // an eviction only happens once the active frames are all filled
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && do_evict |-> filled_q >= active_cnt)
    else $error("eviction while empty frames remain");

endmodule
